[design/etm_pkg.sv]
// Shared types, constants and fixed-point helpers for the Euler angle to
// model matrix pipeline. No dependencies.
`default_nettype none

package etm_pkg;

  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned SincosStages = CordicSteps + 2;   // reduce, steps, round
  localparam int unsigned RotStages    = 7;
  localparam int unsigned PipeStages   = SincosStages + RotStages;

  localparam logic signed [16:0] FullTurn    = 17'sd23040;
  localparam logic [14:0]        QuarterTurn = 15'd5760;
  localparam logic [14:0]        HalfTurn    = 15'd11520;
  localparam logic [14:0]        ThreeQTurn  = 15'd17280;
  localparam logic signed [33:0] GainQ30     = 34'sd652032874;

  localparam logic signed [25:0] AtanTab [CordicSteps] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234378,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef logic signed [17:0] sc_t;    // Q16 sine or cosine
  typedef logic signed [19:0] q16_t;   // Q16 products and vector parts
  typedef logic signed [24:0] vr_t;    // Q16 cross product parts

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } side_t;

  typedef struct packed {
    logic signed [15:0] col0_x;
    logic signed [15:0] col0_y;
    logic signed [15:0] col0_z;
    logic signed [15:0] col1_x;
    logic signed [15:0] col1_y;
    logic signed [15:0] col1_z;
    logic signed [15:0] col2_x;
    logic signed [15:0] col2_y;
    logic signed [15:0] col2_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } res_t;

  // round to nearest, half away from zero
  function automatic logic signed [47:0] rnd(input logic signed [47:0] v,
                                             input int unsigned n);
    logic signed [47:0] half;
    logic signed [47:0] mag;
    half = 48'sd1 <<< (n - 1);
    mag  = -v;
    if (v >= 48'sd0) begin
      rnd = (v + half) >>> n;
    end else begin
      rnd = -((mag + half) >>> n);
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  function automatic q16_t mul16(input q16_t a, input q16_t b);
    logic signed [39:0] p;
    logic signed [47:0] r;
    p = a * b;
    r = rnd({{8{p[39]}}, p}, 16);
    mul16 = r[19:0];
  endfunction

  function automatic q16_t ext_sc(input sc_t v);
    ext_sc = {{2{v[17]}}, v};
  endfunction

endpackage

`default_nettype wire

[design/etm_ifs.sv]
// Valid/ready channel interfaces for the model matrix block.
// Depends on nothing; payload fields at their fixed widths.
`default_nettype none

interface etm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] yaw_deg;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] scale_z;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, pos_x, pos_y, pos_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, pos_x, pos_y, pos_z,
                  scale_x, scale_y, scale_z, output ready);
endinterface

interface etm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] col0_x;
  logic signed [15:0] col0_y;
  logic signed [15:0] col0_z;
  logic signed [15:0] col1_x;
  logic signed [15:0] col1_y;
  logic signed [15:0] col1_z;
  logic signed [15:0] col2_x;
  logic signed [15:0] col2_y;
  logic signed [15:0] col2_z;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                  col2_x, col2_y, col2_z, trans_x, trans_y, trans_z, input ready);
  modport sink   (input valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                  col2_x, col2_y, col2_z, trans_x, trans_y, trans_z, output ready);
endinterface

`default_nettype wire

[design/euler_to_model_matrix.sv]
// Top level: three sine/cosine lanes feeding the rotation and scaling
// stages, with the valid and stall chain. Depends on etm_pkg, etm_ifs.
//
//   channel | dir | carries
//   in_i    | in  | roll/pitch/yaw (1/64 deg), position Q16.16, scale Q8.8
//   out_o   | out | three scaled columns Q8.8, translation Q16.16
//
// Items pass through the CORDIC lanes, then the matrix stages.
// One item per cycle is taken while the output is drained.
// A stalled output holds; bubbles ahead of it still close up, so the
// input stays ready while any stage is empty.
// Reset clears the valid bits only.
`default_nettype none

module euler_to_model_matrix
  import etm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  etm_in_if.sink    in_i,
  etm_out_if.source out_o
);

  logic [PipeStages-1:0] v_q;
  logic [PipeStages-1:0] en_w;
  side_t                 side_q [SincosStages];
  side_t                 side_w;
  sc_t                   sa_w, ca_w, sb_w, cb_w, sg_w, cg_w;
  res_t                  res_w;

  always_comb begin
    en_w[PipeStages-1] = !v_q[PipeStages-1] || out_o.ready;
    for (int k = PipeStages - 2; k >= 0; k--) begin
      en_w[k] = !v_q[k] || en_w[k+1];
    end
  end

  assign in_i.ready = en_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_w[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < PipeStages; k++) begin
        if (en_w[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign side_w.pos_x   = in_i.pos_x;
  assign side_w.pos_y   = in_i.pos_y;
  assign side_w.pos_z   = in_i.pos_z;
  assign side_w.scale_x = in_i.scale_x;
  assign side_w.scale_y = in_i.scale_y;
  assign side_w.scale_z = in_i.scale_z;

  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      side_q[0] <= side_w;
    end
    for (int k = 1; k < SincosStages; k++) begin
      if (en_w[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  etm_sincos u_roll (
    .clk_i (clk_i),
    .en_i  (en_w[SincosStages-1:0]),
    .ang_i (in_i.roll_deg),
    .sin_o (sa_w),
    .cos_o (ca_w)
  );

  etm_sincos u_pitch (
    .clk_i (clk_i),
    .en_i  (en_w[SincosStages-1:0]),
    .ang_i (in_i.pitch_deg),
    .sin_o (sb_w),
    .cos_o (cb_w)
  );

  etm_sincos u_yaw (
    .clk_i (clk_i),
    .en_i  (en_w[SincosStages-1:0]),
    .ang_i (in_i.yaw_deg),
    .sin_o (sg_w),
    .cos_o (cg_w)
  );

  etm_rot u_rot (
    .clk_i  (clk_i),
    .en_i   (en_w[PipeStages-1:SincosStages]),
    .sa_i   (sa_w),
    .ca_i   (ca_w),
    .sb_i   (sb_w),
    .cb_i   (cb_w),
    .sg_i   (sg_w),
    .cg_i   (cg_w),
    .side_i (side_q[SincosStages-1]),
    .res_o  (res_w)
  );

  assign out_o.valid   = v_q[PipeStages-1];
  assign out_o.col0_x  = res_w.col0_x;
  assign out_o.col0_y  = res_w.col0_y;
  assign out_o.col0_z  = res_w.col0_z;
  assign out_o.col1_x  = res_w.col1_x;
  assign out_o.col1_y  = res_w.col1_y;
  assign out_o.col1_z  = res_w.col1_z;
  assign out_o.col2_x  = res_w.col2_x;
  assign out_o.col2_y  = res_w.col2_y;
  assign out_o.col2_z  = res_w.col2_z;
  assign out_o.trans_x = res_w.trans_x;
  assign out_o.trans_y = res_w.trans_y;
  assign out_o.trans_z = res_w.trans_z;

endmodule

`default_nettype wire

[design/etm_sincos.sv]
// One sine/cosine lane: angle reduction, 16 pipelined CORDIC steps, then
// rounding and quadrant fold. Depends on etm_pkg.
`default_nettype none

module etm_sincos
  import etm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic [SincosStages-1:0] en_i,
  input  wire logic signed [15:0]      ang_i,
  output sc_t                          sin_o,
  output sc_t                          cos_o
);

  logic signed [16:0] t_w;
  logic [14:0]        a_w;
  quad_e              q_w;
  logic [14:0]        r_w;

  quad_e              q0_q;
  logic signed [25:0] z0_q;

  logic signed [33:0] x_q [CordicSteps];
  logic signed [33:0] y_q [CordicSteps];
  logic signed [25:0] z_q [CordicSteps];
  quad_e              qs_q [CordicSteps];

  always_comb begin
    t_w = {ang_i[15], ang_i};
    if (t_w < 17'sd0) begin
      t_w = t_w + FullTurn;
    end
    if (t_w < 17'sd0) begin
      t_w = t_w + FullTurn;
    end
    if (t_w >= FullTurn) begin
      t_w = t_w - FullTurn;
    end
    a_w = t_w[14:0];
    if (a_w >= ThreeQTurn) begin
      q_w = QUAD_3;
      r_w = a_w - ThreeQTurn;
    end else if (a_w >= HalfTurn) begin
      q_w = QUAD_2;
      r_w = a_w - HalfTurn;
    end else if (a_w >= QuarterTurn) begin
      q_w = QUAD_1;
      r_w = a_w - QuarterTurn;
    end else begin
      q_w = QUAD_0;
      r_w = a_w;
    end
  end

  // residual angle in 1/65536 degree, never negative
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q0_q <= q_w;
      z0_q <= $signed({3'b0, r_w[12:0], 10'b0});
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [25:0] z_in;
    quad_e              q_in;
    logic signed [33:0] xs;
    logic signed [33:0] ys;

    if (i == 0) begin : g_first
      assign x_in = GainQ30;
      assign y_in = 34'sd0;
      assign z_in = z0_q;
      assign q_in = q0_q;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign q_in = qs_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        qs_q[i] <= q_in;
        if (z_in >= 26'sd0) begin
          x_q[i] <= x_in - ys;
          y_q[i] <= y_in + xs;
          z_q[i] <= z_in - AtanTab[i];
        end else begin
          x_q[i] <= x_in + ys;
          y_q[i] <= y_in - xs;
          z_q[i] <= z_in + AtanTab[i];
        end
      end
    end
  end

  logic signed [47:0] sr_w;
  logic signed [47:0] cr_w;
  sc_t                sv_w;
  sc_t                cv_w;

  assign sr_w = rnd({{14{y_q[CordicSteps-1][33]}}, y_q[CordicSteps-1]}, 14);
  assign cr_w = rnd({{14{x_q[CordicSteps-1][33]}}, x_q[CordicSteps-1]}, 14);
  assign sv_w = sr_w[17:0];
  assign cv_w = cr_w[17:0];

  always_ff @(posedge clk_i) begin
    if (en_i[SincosStages-1]) begin
      case (qs_q[CordicSteps-1])
        QUAD_0: begin
          sin_o <= sv_w;
          cos_o <= cv_w;
        end
        QUAD_1: begin
          sin_o <= cv_w;
          cos_o <= -sv_w;
        end
        QUAD_2: begin
          sin_o <= -sv_w;
          cos_o <= -cv_w;
        end
        default: begin
          sin_o <= -cv_w;
          cos_o <= sv_w;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/etm_rot.sv]
// Rotation columns, cross product and per-axis scaling over seven register
// stages; carries position and scale alongside. Depends on etm_pkg.
`default_nettype none

module etm_rot
  import etm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic [RotStages-1:0] en_i,
  input  wire sc_t                  sa_i,
  input  wire sc_t                  ca_i,
  input  wire sc_t                  sb_i,
  input  wire sc_t                  cb_i,
  input  wire sc_t                  sg_i,
  input  wire sc_t                  cg_i,
  input  wire side_t                side_i,
  output res_t                      res_o
);

  side_t side_q [RotStages-1];

  // stage 1: pair products of sines and cosines
  q16_t sacb_q, casb_q, cbcg_q, casg_q, sasg_q, cbsg_q, cacg_q, sacg_q, cg1_q, sg1_q;
  // stage 2: triple products
  q16_t p1_q, p2_q, p3_q, p4_q, cbcg2_q, casg2_q, sasg2_q, cbsg2_q, cacg2_q, sacg2_q;
  // stage 3: front and up vectors
  q16_t vf_q [3];
  q16_t vu_q [3];
  // stage 4: raw products
  logic signed [39:0] xp_q [6];
  logic signed [35:0] kf_q [3];
  logic signed [35:0] ku_q [3];
  // stage 5
  vr_t                vr_q [3];
  logic signed [15:0] cf5_q [3];
  logic signed [15:0] cu5_q [3];
  // stage 6
  logic signed [40:0] kr_q [3];
  logic signed [15:0] cf6_q [3];
  logic signed [15:0] cu6_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= side_i;
      sacb_q    <= mul16(ext_sc(sa_i), ext_sc(sb_i));
      casb_q    <= mul16(ext_sc(ca_i), ext_sc(sb_i));
      cbcg_q    <= mul16(ext_sc(cb_i), ext_sc(cg_i));
      casg_q    <= mul16(ext_sc(ca_i), ext_sc(sg_i));
      sasg_q    <= mul16(ext_sc(sa_i), ext_sc(sg_i));
      cbsg_q    <= mul16(ext_sc(cb_i), ext_sc(sg_i));
      cacg_q    <= mul16(ext_sc(ca_i), ext_sc(cg_i));
      sacg_q    <= mul16(ext_sc(sa_i), ext_sc(cg_i));
      cg1_q     <= ext_sc(cg_i);
      sg1_q     <= ext_sc(sg_i);
    end
    if (en_i[1]) begin
      side_q[1] <= side_q[0];
      p1_q      <= mul16(sacb_q, cg1_q);
      p2_q      <= mul16(casb_q, cg1_q);
      p3_q      <= mul16(sacb_q, sg1_q);
      p4_q      <= mul16(casb_q, sg1_q);
      cbcg2_q   <= cbcg_q;
      casg2_q   <= casg_q;
      sasg2_q   <= sasg_q;
      cbsg2_q   <= cbsg_q;
      cacg2_q   <= cacg_q;
      sacg2_q   <= sacg_q;
    end
    if (en_i[2]) begin
      side_q[2] <= side_q[1];
      vf_q[0]   <= cbcg2_q;
      vf_q[1]   <= p1_q + casg2_q;
      vf_q[2]   <= sasg2_q - p2_q;
      vu_q[0]   <= -cbsg2_q;
      vu_q[1]   <= cacg2_q - p3_q;
      vu_q[2]   <= p4_q + sacg2_q;
    end
    if (en_i[3]) begin
      side_q[3] <= side_q[2];
      xp_q[0]   <= vf_q[1] * vu_q[2];
      xp_q[1]   <= vf_q[2] * vu_q[1];
      xp_q[2]   <= vf_q[2] * vu_q[0];
      xp_q[3]   <= vf_q[0] * vu_q[2];
      xp_q[4]   <= vf_q[0] * vu_q[1];
      xp_q[5]   <= vf_q[1] * vu_q[0];
      for (int j = 0; j < 3; j++) begin
        kf_q[j] <= side_q[2].scale_x * vf_q[j];
        ku_q[j] <= side_q[2].scale_y * vu_q[j];
      end
    end
  end

  logic signed [47:0] xd_w [3];
  logic signed [47:0] xr_w [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      xd_w[j] = {{8{xp_q[2*j][39]}}, xp_q[2*j]} - {{8{xp_q[2*j+1][39]}}, xp_q[2*j+1]};
      xr_w[j] = rnd(xd_w[j], 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      side_q[4] <= side_q[3];
      for (int j = 0; j < 3; j++) begin
        vr_q[j]  <= xr_w[j][24:0];
        cf5_q[j] <= sat16(rnd({{12{kf_q[j][35]}}, kf_q[j]}, 16));
        cu5_q[j] <= sat16(rnd({{12{ku_q[j][35]}}, ku_q[j]}, 16));
      end
    end
    if (en_i[5]) begin
      side_q[5] <= side_q[4];
      for (int j = 0; j < 3; j++) begin
        kr_q[j]  <= side_q[4].scale_z * vr_q[j];
        cf6_q[j] <= cf5_q[j];
        cu6_q[j] <= cu5_q[j];
      end
    end
    if (en_i[6]) begin
      res_o.col0_x  <= cf6_q[0];
      res_o.col0_y  <= cf6_q[1];
      res_o.col0_z  <= cf6_q[2];
      res_o.col1_x  <= cu6_q[0];
      res_o.col1_y  <= cu6_q[1];
      res_o.col1_z  <= cu6_q[2];
      res_o.col2_x  <= sat16(rnd({{7{kr_q[0][40]}}, kr_q[0]}, 16));
      res_o.col2_y  <= sat16(rnd({{7{kr_q[1][40]}}, kr_q[1]}, 16));
      res_o.col2_z  <= sat16(rnd({{7{kr_q[2][40]}}, kr_q[2]}, 16));
      res_o.trans_x <= side_q[5].pos_x;
      res_o.trans_y <= side_q[5].pos_y;
      res_o.trans_z <= side_q[5].pos_z;
    end
  end

endmodule

`default_nettype wire

[design/etm_checker.sv]
// Port-level checks for the model matrix block, bound to the top level.
// Depends on euler_to_model_matrix.
`default_nettype none

module etm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_col0_x,
  input wire logic signed [31:0] out_trans_x
);

  // a waiting item holds its col0_x and trans_x payload fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_col0_x) && $stable(out_trans_x))
    else $error("output item changed while stalled");

  // a drained output frees the whole pipe
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind euler_to_model_matrix etm_checker u_etm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_col0_x  (out_o.col0_x),
  .out_trans_x (out_o.trans_x)
);

`default_nettype wire
